### design/crtc_pkg.sv
// Shared types, codes and constants for the call/return trace classifier.
package crtc_pkg;

  localparam int FUNC_ENTRIES_DEF = 64;

  localparam logic [6:0]  JUMP_MASK   = 7'b1110111;
  localparam logic [6:0]  JUMP_OPCODE = 7'b1100111;
  localparam logic [4:0]  RD_ZERO     = 5'b00000;
  localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_CALL   = 2'd1;
  localparam logic [1:0] KIND_RETURN = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] entry_start;
    logic [31:0] entry_size;
    logic [31:0] instr_word;
    logic [31:0] next_pc;
  } item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] target_pc;
    logic [15:0] call_depth;
    logic [5:0]  func_index;
    logic        ret_underflow;
  } result_t;

  // Lookup token passed from cell to cell.
  typedef struct packed {
    logic        active;
    logic [31:0] target;
    logic        hit;
    logic        at_start;
  } token_t;

endpackage

### design/call_return_trace_classifier.sv
// Top level of the call/return trace classifier: cell chain, control and result register.
//
// Input channel item/item_valid/item_ready carries load transactions (command 0),
// which store a function range in the next free cell, and retired instruction
// transactions (command 1). Output channel result/result_valid/result_ready gives
// one record for each jal/jalr whose target is unmatched, a call or a return.
// Loads, non-jumps and events on an empty table give nothing.
// A jump lookup walks the token through the chain of FUNC_ENTRIES cells, one cell
// per cycle, newest matching cell winning; no new item is taken until it is done.
// The token leaves the last cell during ST_SEARCH, the lookup is captured, and in
// ST_FINISH the record is written to the result register; a matched jump that is
// neither a call nor a return gives nothing.
// The result register decouples the sides: a new item is taken while a record
// waits; a finished lookup waits in place while the receiver stalls.
// Reset (rst, synchronous) empties the table and clears the call depth.
module call_return_trace_classifier #(
  parameter int FUNC_ENTRIES = crtc_pkg::FUNC_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  crtc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output crtc_pkg::result_t result
);
  import crtc_pkg::*;

  localparam int IDX_W = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FUNC_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] entry_count;
  logic [15:0]      depth_counter;

  token_t           tok_chain [0:FUNC_ENTRIES];
  logic [IDX_W-1:0] idx_chain [0:FUNC_ENTRIES];

  logic             accept;
  logic             is_load;
  logic             is_jump;
  logic             launch;
  logic             rd_nonzero;

  logic             hit;
  logic             at_start;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      target;

  logic             emit;
  logic [1:0]       kind;
  logic             out_free;
  logic [IDX_W+5:0] idx_wide;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign is_load    = accept && (item.command == CMD_LOAD);
  assign is_jump    = (item.instr_word[6:0] & JUMP_MASK) == JUMP_OPCODE;
  assign launch     = accept && (item.command == CMD_EVENT) && is_jump &&
                      (entry_count != '0);

  always_comb begin
    tok_chain[0].active   = launch;
    tok_chain[0].target   = item.next_pc;
    tok_chain[0].hit      = 1'b0;
    tok_chain[0].at_start = 1'b0;
    idx_chain[0]          = '0;
  end

  for (genvar k = 0; k < FUNC_ENTRIES; k++) begin : g_cell
    crtc_cell #(
      .CELL_INDEX (k),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .load        (is_load),
      .load_start  (item.entry_start),
      .load_size   (item.entry_size),
      .entry_count (entry_count),
      .tok_in      (tok_chain[k]),
      .idx_in      (idx_chain[k]),
      .tok_out     (tok_chain[k+1]),
      .idx_out     (idx_chain[k+1])
    );
  end

  always_comb begin
    emit = 1'b1;
    kind = KIND_OTHER;
    if (hit) begin
      if (rd_nonzero && at_start) begin
        kind = KIND_CALL;
      end else if (!rd_nonzero && !at_start) begin
        kind = KIND_RETURN;
      end else begin
        emit = 1'b0;
      end
    end
  end

  assign out_free = !result_valid || result_ready;
  assign idx_wide = {6'b0, hit_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      depth_counter <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (state == ST_FINISH && emit && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (is_load && entry_count != CNT_W'(FUNC_ENTRIES)) begin
            entry_count <= entry_count + CNT_W'(1);
          end
          if (launch) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tok_chain[FUNC_ENTRIES].active) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!emit) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
            if (kind == KIND_CALL && depth_counter != DEPTH_MAX) begin
              depth_counter <= depth_counter + 16'd1;
            end else if (kind == KIND_RETURN && depth_counter != 16'd0) begin
              depth_counter <= depth_counter - 16'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      rd_nonzero <= (item.instr_word[11:7] != RD_ZERO);
    end
    if (state == ST_SEARCH && tok_chain[FUNC_ENTRIES].active) begin
      hit      <= tok_chain[FUNC_ENTRIES].hit;
      at_start <= tok_chain[FUNC_ENTRIES].at_start;
      target   <= tok_chain[FUNC_ENTRIES].target;
      hit_idx  <= idx_chain[FUNC_ENTRIES];
    end
    if (state == ST_FINISH && emit && out_free) begin
      result.record_kind   <= kind;
      result.target_pc     <= target;
      result.call_depth    <= depth_counter;
      result.func_index    <= hit ? idx_wide[5:0] : 6'd0;
      result.ret_underflow <= (kind == KIND_RETURN) && (depth_counter == 16'd0);
    end
  end

endmodule

### design/crtc_cell.sv
// One table cell: holds a function range and tests the passing lookup token against it.
module crtc_cell #(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [31:0]         load_start,
  input  logic [31:0]         load_size,
  input  logic [CNT_W-1:0]    entry_count,
  input  crtc_pkg::token_t    tok_in,
  input  logic [IDX_W-1:0]    idx_in,
  output crtc_pkg::token_t    tok_out,
  output logic [IDX_W-1:0]    idx_out
);
  import crtc_pkg::*;

  logic [31:0] range_start;
  logic [31:0] range_size;
  logic [31:0] range_end;
  logic        cell_used;
  logic        match;
  token_t      tok_next;
  logic [IDX_W-1:0] idx_next;

  assign range_end = range_start + range_size;
  assign cell_used = CNT_W'(CELL_INDEX) < entry_count;
  assign match     = tok_in.active && cell_used &&
                     (tok_in.target >= range_start) && (tok_in.target < range_end);

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    if (match) begin
      tok_next.hit      = 1'b1;
      tok_next.at_start = (tok_in.target == range_start);
      idx_next          = IDX_W'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (load && entry_count == CNT_W'(CELL_INDEX)) begin
      range_start <= load_start;
      range_size  <= load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.target   <= tok_next.target;
    tok_out.hit      <= tok_next.hit;
    tok_out.at_start <= tok_next.at_start;
    idx_out          <= idx_next;
  end

endmodule
